// ===== hdl/rgdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rgdq_pkg: shared types and codes for the rate-gated drop-oldest queue
// Request and response item layouts, request codes, status codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package rgdq_pkg;

    localparam int HANDLE_W   = 32;
    localparam int TICK_W     = 64;
    localparam int INTERVAL_W = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    // request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    // status codes
    localparam logic [2:0] ST_STORED      = 3'd0;
    localparam logic [2:0] ST_RATE_SKIP   = 3'd1;
    localparam logic [2:0] ST_DISABLED    = 3'd2;
    localparam logic [2:0] ST_POPPED      = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;
    localparam logic [2:0] ST_FLUSHED     = 3'd5;
    localparam logic [2:0] ST_FLUSH_EMPTY = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENABLED  = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [HANDLE_W-1:0] frame_handle;
        logic [TICK_W-1:0]   tick_ms;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] out_handle;
        logic                evicted_valid;
        logic [HANDLE_W-1:0] evicted_handle;
        logic                last;
    } rsp_t;

endpackage

// ===== hdl/rgdq_chan_if.sv =====
// ----------------------------------------------------------------------------
// rgdq_chan_if: valid/ready channel
// Carries one payload item per handshake; source drives valid and payload,
// sink drives ready.
// ----------------------------------------------------------------------------
interface rgdq_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/rate_gated_drop_oldest_queue.sv =====
// ----------------------------------------------------------------------------
// rate_gated_drop_oldest_queue: per-client frame queue with drop-oldest ring
// Push stores a handle (rate gated, evicting the oldest when full), pop
// returns the oldest handle, flush drains every stored handle in order.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake           Item
//  -------  ---  ------------------  -----------------------------------------
//  req      in   req.valid/ready     req_type, frame_handle, tick_ms
//  rsp      out  rsp.valid/ready     status, out_handle, evicted_valid,
//                                    evicted_handle, last
//  cfg      in   cfg_write           cfg_index, cfg_data (no read-back)
//
//  Sequence: a request is accepted in S_IDLE, then decided in S_EXEC. Push
//  without eviction and every refused/empty case finish there; pop and
//  evicting push go on to S_READ for the ring read. Flush streams one
//  entry per cycle from the ring's single read port while rsp is not
//  stalled. Stalls on rsp hold the block in place.
//  Reset: pointers, fill count and last-accept tick cleared, interval 0,
//  queue enabled. The ring memory itself is not cleared.
//
module rate_gated_drop_oldest_queue #(
    parameter int QUEUE_DEPTH = 8,
    parameter int HANDLE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rgdq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgdq_pkg::CFG_DATA_W-1:0]    cfg_data,
    rgdq_chan_if.sink                          req,
    rgdq_chan_if.source                        rsp
);
    // stored handle width: handle bits from HANDLE_BITS up are never stored
    localparam int STORE_W = (HANDLE_BITS < rgdq_pkg::HANDLE_W) ?
                             HANDLE_BITS : rgdq_pkg::HANDLE_W;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,   // waiting for a request
        S_EXEC = 3'b010,   // decide; finish or issue ring read
        S_READ = 3'b100    // ring data valid; emit
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ---------------- registers ----------------
    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [rgdq_pkg::TICK_W-1:0]     tick_reg, tick_next;
    logic [rgdq_pkg::INTERVAL_W-1:0] interval_reg;
    logic                            enabled_reg;

    // captured request (payload, no reset)
    logic [1:0]                      req_type_reg;
    logic [STORE_W-1:0]              handle_reg;
    logic [rgdq_pkg::TICK_W-1:0]     req_tick_reg;

    // output stage
    logic                            out_valid_reg, out_valid_next;
    rgdq_pkg::rsp_t                  out_reg;
    rgdq_pkg::rsp_t                  res;
    logic                            emit;
    logic                            out_free;

    // ring memory, registered read
    logic [STORE_W-1:0]              ring [QUEUE_DEPTH];
    logic [STORE_W-1:0]              ring_q;
    logic                            mem_we;
    logic                            mem_re;

    logic                            full;
    logic                            gate_skip;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    rgdq_rate_gate u_rate_gate (
        .tick      (req_tick_reg),
        .last_tick (tick_reg),
        .interval  (interval_reg),
        .skip      (gate_skip)
    );

    // ---------------- sequencer ----------------
    // Writes and reads of the ring never hit the same entry in one cycle:
    // an evicting push writes only after its read has returned, and flush
    // reads never coincide with a write. No forwarding is needed.
    always_comb
    begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        tick_next   = tick_reg;
        emit        = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        res         = '0;
        res.last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    case (req_type_reg)
                        rgdq_pkg::REQ_PUSH:
                        begin
                            if (!enabled_reg)
                            begin
                                emit       = 1'b1;
                                res.status = rgdq_pkg::ST_DISABLED;
                            end
                            else if (gate_skip)
                            begin
                                emit       = 1'b1;
                                res.status = rgdq_pkg::ST_RATE_SKIP;
                            end
                            else if (full)
                            begin
                                // fetch the oldest entry for eviction
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                wr_ptr_next = ptr_inc(wr_ptr_reg);
                                cnt_next    = cnt_reg + 1'b1;
                                if (interval_reg != '0)
                                begin
                                    tick_next = req_tick_reg;
                                end
                                emit       = 1'b1;
                                res.status = rgdq_pkg::ST_STORED;
                            end
                        end

                        rgdq_pkg::REQ_POP:
                        begin
                            if (!enabled_reg)
                            begin
                                emit       = 1'b1;
                                res.status = rgdq_pkg::ST_DISABLED;
                            end
                            else if (cnt_reg == '0)
                            begin
                                emit       = 1'b1;
                                res.status = rgdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end

                        rgdq_pkg::REQ_FLUSH:
                        begin
                            // flush ignores the enable
                            if (cnt_reg == '0)
                            begin
                                emit       = 1'b1;
                                res.status = rgdq_pkg::ST_FLUSH_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end

                        default:
                        begin
                            // unknown request: dropped silently
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    state_next  = S_IDLE;
                    case (req_type_reg)
                        rgdq_pkg::REQ_PUSH:
                        begin
                            // evict oldest, store new; fill count unchanged
                            mem_we             = 1'b1;
                            wr_ptr_next        = ptr_inc(wr_ptr_reg);
                            if (interval_reg != '0)
                            begin
                                tick_next = req_tick_reg;
                            end
                            res.status         = rgdq_pkg::ST_STORED;
                            res.evicted_valid  = 1'b1;
                            res.evicted_handle = rgdq_pkg::HANDLE_W'(ring_q);
                        end

                        rgdq_pkg::REQ_POP:
                        begin
                            cnt_next       = cnt_reg - 1'b1;
                            res.status     = rgdq_pkg::ST_POPPED;
                            res.out_handle = rgdq_pkg::HANDLE_W'(ring_q);
                        end

                        default:
                        begin
                            // flush walk: one entry per cycle while rsp is not stalled
                            cnt_next       = cnt_reg - 1'b1;
                            res.status     = rgdq_pkg::ST_FLUSHED;
                            res.out_handle = rgdq_pkg::HANDLE_W'(ring_q);
                            res.last       = (cnt_reg == CNT_W'(1));
                            if (cnt_reg != CNT_W'(1))
                            begin
                                mem_re     = 1'b1;
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            interval_reg  <= '0;
            enabled_reg   <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            cnt_reg       <= cnt_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    rgdq_pkg::CFG_FRAME_INTERVAL:
                    begin
                        interval_reg <= cfg_data[rgdq_pkg::INTERVAL_W-1:0];
                    end
                    rgdq_pkg::CFG_QUEUE_ENABLED:
                    begin
                        enabled_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        enabled_reg <= enabled_reg;
                    end
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_type_reg <= req.payload.req_type;
            handle_reg   <= req.payload.frame_handle[STORE_W-1:0];
            req_tick_reg <= req.payload.tick_ms;
        end
        if (emit)
        begin
            out_reg <= res;
        end
    end

    // ---------------- ring memory ----------------
    // write always goes to the tail; read address follows the head after
    // this cycle's update so flush streams the next entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring[wr_ptr_reg] <= handle_reg;
        end
        if (mem_re)
        begin
            ring_q <= ring[rd_ptr_next];
        end
    end

`ifndef SYNTHESIS
    // fill count stays within the ring
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond ring depth");

    // head and tail meet whenever the ring is empty or full
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || full) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("ring pointers inconsistent with fill count");

    // a ring read is only ever pending on a non-empty ring
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (cnt_reg != '0))
        else $error("ring read pending while empty");

    // an evicting push keeps the ring full
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.evicted_valid) |=> full)
        else $error("eviction left ring not full");
`endif

endmodule

// ===== hdl/rgdq_rate_gate.sv =====
// ----------------------------------------------------------------------------
// rgdq_rate_gate: push rate gate
// Flags a push that comes too soon after the last accepted one. Exact
// compare, no wrap: a tick behind the last accepted tick is also too soon.
// ----------------------------------------------------------------------------
module rgdq_rate_gate (
    input  logic [rgdq_pkg::TICK_W-1:0]     tick,
    input  logic [rgdq_pkg::TICK_W-1:0]     last_tick,
    input  logic [rgdq_pkg::INTERVAL_W-1:0] interval,
    output logic                            skip
);
    logic [rgdq_pkg::TICK_W:0] diff;

    assign diff = {1'b0, tick} - {1'b0, last_tick};
    assign skip = (interval != '0) &&
                  (diff[rgdq_pkg::TICK_W] ||
                   (diff[rgdq_pkg::TICK_W-1:0] < rgdq_pkg::TICK_W'(interval)));
endmodule

// ===== tb/tb_rate_gated_drop_oldest_queue.sv =====
// ----------------------------------------------------------------------------
// tb_rate_gated_drop_oldest_queue: self-checking bench for the frame queue
// Drives push, pop, flush and unknown requests through the request channel
// under random idle and stall. A behavioral copy of the queue predicts every
// response, and each response is checked field by field in arrival order.
// Register settings change only while the block is idle.
// ----------------------------------------------------------------------------
module tb_rate_gated_drop_oldest_queue;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 8;
    localparam int DRAIN_WAIT = 12;
    localparam int STALL_MAX  = 4000;   // cycles with no handshake at all
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 36;
    localparam logic [63:0] TICK_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [1:0]  REQ_BOGUS = 2'd3;  // not a defined request

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [rgdq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rgdq_pkg::CFG_DATA_W-1:0] cfg_data;

    rgdq_chan_if #(.payload_t(rgdq_pkg::req_t)) req_if ();
    rgdq_chan_if #(.payload_t(rgdq_pkg::rsp_t)) rsp_if ();

    rate_gated_drop_oldest_queue #(
        .QUEUE_DEPTH (DEPTH),
        .HANDLE_BITS (rgdq_pkg::HANDLE_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // ------------------------------------------------------------------
    // Shadow of the queue: ring, pointers, fill level, gate state, regs
    // ------------------------------------------------------------------
    logic [rgdq_pkg::HANDLE_W-1:0]   ring [DEPTH];
    logic [2:0]                      rd_idx;
    logic [2:0]                      wr_idx;
    logic [3:0]                      fill;
    logic [rgdq_pkg::TICK_W-1:0]     last_tick;
    logic [rgdq_pkg::INTERVAL_W-1:0] gap_ms;
    logic                            q_enabled;

    rgdq_pkg::req_t pend_q[$];           // items waiting for the driver
    rgdq_pkg::rsp_t expected_rsp_q[$];   // responses owed by the block, oldest first

    bit calm;                  // set for one phase: neither side idles
    int errors;
    int items_sent;
    int rsp_seen;
    int evictions_seen;
    int flush_entries_seen;
    int skips_seen;
    int idle_cycles;

    // Works out the responses of one accepted item and updates the shadow.
    function automatic void predict_frame_queue(input rgdq_pkg::req_t r);
        rgdq_pkg::rsp_t o;
        o      = '0;
        o.last = 1'b1;
        case (r.req_type)
            rgdq_pkg::REQ_PUSH:
            begin
                if (!q_enabled)
                begin
                    o.status = rgdq_pkg::ST_DISABLED;
                end
                else if (gap_ms != 0 &&
                         (r.tick_ms < last_tick || r.tick_ms - last_tick < gap_ms))
                begin
                    // gate never wraps: a tick behind the last one is a skip
                    o.status = rgdq_pkg::ST_RATE_SKIP;
                end
                else
                begin
                    if (gap_ms != 0)
                        last_tick = r.tick_ms;
                    if (fill == DEPTH)
                    begin
                        // drop oldest to make room
                        o.evicted_valid  = 1'b1;
                        o.evicted_handle = ring[rd_idx];
                        rd_idx           = rd_idx + 3'd1;
                        fill             = fill - 4'd1;
                    end
                    ring[wr_idx] = r.frame_handle;
                    wr_idx       = wr_idx + 3'd1;
                    fill         = fill + 4'd1;
                    o.status     = rgdq_pkg::ST_STORED;
                end
                expected_rsp_q.push_back(o);
            end
            rgdq_pkg::REQ_POP:
            begin
                if (!q_enabled)
                    o.status = rgdq_pkg::ST_DISABLED;
                else if (fill == 0)
                    o.status = rgdq_pkg::ST_EMPTY;
                else
                begin
                    o.status     = rgdq_pkg::ST_POPPED;
                    o.out_handle = ring[rd_idx];
                    rd_idx       = rd_idx + 3'd1;
                    fill         = fill - 4'd1;
                end
                expected_rsp_q.push_back(o);
            end
            rgdq_pkg::REQ_FLUSH:
            begin
                // flush ignores the enable
                if (fill == 0)
                begin
                    o.status = rgdq_pkg::ST_FLUSH_EMPTY;
                    expected_rsp_q.push_back(o);
                end
                else
                begin
                    while (fill != 0)
                    begin
                        o.status     = rgdq_pkg::ST_FLUSHED;
                        o.out_handle = ring[rd_idx];
                        o.last       = (fill == 4'd1);
                        expected_rsp_q.push_back(o);
                        rd_idx = rd_idx + 3'd1;
                        fill   = fill - 4'd1;
                    end
                end
            end
            default: ;  // unknown request: no response, no state change
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        errors++;
        $display("MISMATCH @%0t ns: %s", $realtime, msg);
    endtask

    task automatic check_rsp(input rgdq_pkg::rsp_t got, input rgdq_pkg::rsp_t want);
        if (got.status !== want.status)
            note_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.out_handle !== want.out_handle)
            note_mismatch($sformatf("out_handle got %h want %h",
                                    got.out_handle, want.out_handle));
        if (got.evicted_valid !== want.evicted_valid)
            note_mismatch($sformatf("evicted_valid got %b want %b",
                                    got.evicted_valid, want.evicted_valid));
        if (got.evicted_handle !== want.evicted_handle)
            note_mismatch($sformatf("evicted_handle got %h want %h",
                                    got.evicted_handle, want.evicted_handle));
        if (got.last !== want.last)
            note_mismatch($sformatf("last got %b want %b", got.last, want.last));
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver: offers the next pending item, holds it until taken.
    // Prediction runs at the accepting edge, so the shadow always sees
    // items in the same order as the block.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                predict_frame_queue(req_if.payload);
                items_sent++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 24))
                begin
                    req_if.payload <= pend_q.pop_front();
                    req_if.valid   <= 1'b1;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: checks each taken item against the oldest
    // expectation and stalls the block at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            rsp_seen++;
            if (rsp_if.payload.evicted_valid === 1'b1)
                evictions_seen++;
            if (rsp_if.payload.status === rgdq_pkg::ST_FLUSHED)
                flush_entries_seen++;
            if (rsp_if.payload.status === rgdq_pkg::ST_RATE_SKIP)
                skips_seen++;
            if (expected_rsp_q.size() == 0)
                note_mismatch($sformatf("unexpected response, status %0d",
                                        rsp_if.payload.status));
            else
                check_rsp(rsp_if.payload, expected_rsp_q.pop_front());
        end
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= 24);
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) ||
            (rsp_if.valid && rsp_if.ready) || cfg_write)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_MAX)
        begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [1:0] kind,
                            input logic [rgdq_pkg::HANDLE_W-1:0] h,
                            input logic [rgdq_pkg::TICK_W-1:0] t);
        rgdq_pkg::req_t r;
        r.req_type     = kind;
        r.frame_handle = h;
        r.tick_ms      = t;
        pend_q.push_back(r);
    endtask

    // Waits until every item is taken and every response has come back,
    // then lets an unknown-request tail drain before a register write.
    task automatic settle();
        @(negedge clk);
        while (pend_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Register write; the shadow copy is updated as cfg_write is raised, before the block takes the write.
    task automatic write_reg(input logic [rgdq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rgdq_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == rgdq_pkg::CFG_FRAME_INTERVAL)
            gap_ms = val[rgdq_pkg::INTERVAL_W-1:0];
        else
            q_enabled = val[0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [rgdq_pkg::TICK_W-1:0]     tick_now;
        logic [rgdq_pkg::TICK_W-1:0]     t;
        logic [rgdq_pkg::INTERVAL_W-1:0] gap_pick;
        logic                            en_pick;
        int                              roll;
        int                              p;
        int                              i;

        // everything known from time zero
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        calm           = 1'b0;
        errors         = 0;
        items_sent     = 0;
        rsp_seen       = 0;
        evictions_seen = 0;
        flush_entries_seen = 0;
        skips_seen     = 0;
        idle_cycles    = 0;

        // shadow reset state
        for (i = 0; i < DEPTH; i++)
            ring[i] = '0;
        rd_idx    = '0;
        wr_idx    = '0;
        fill      = '0;
        last_tick = '0;
        gap_ms    = '0;
        q_enabled = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed: reset settings, no gate ---
        add_item(rgdq_pkg::REQ_POP,   32'h0, 64'h0);            // pop on empty ring
        add_item(rgdq_pkg::REQ_FLUSH, 32'h0, 64'h0);            // flush of empty ring
        add_item(rgdq_pkg::REQ_PUSH,  32'h0000_0000, 64'h0);
        add_item(rgdq_pkg::REQ_PUSH,  32'hFFFF_FFFF, TICK_MAX); // gate off: tick unused
        for (i = 0; i < 6; i++)
            add_item(rgdq_pkg::REQ_PUSH, $urandom(), {$urandom(), $urandom()});
        add_item(rgdq_pkg::REQ_PUSH,  $urandom(), 64'h5);       // full: evicts first
        add_item(rgdq_pkg::REQ_PUSH,  $urandom(), 64'h6);       // evicts all-ones handle
        add_item(rgdq_pkg::REQ_POP,   32'h0, 64'h0);
        add_item(REQ_BOGUS, 32'hFFFF_FFFF, TICK_MAX);           // ignored request
        add_item(rgdq_pkg::REQ_FLUSH, 32'h0, 64'h0);            // seven entries out
        add_item(rgdq_pkg::REQ_POP,   32'h0, 64'h0);
        settle();

        // --- directed: 1000 ms gate ---
        write_reg(rgdq_pkg::CFG_FRAME_INTERVAL, 10'd1000);
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd0);     // 0 after 0: too soon
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd999);   // one short
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd1000);  // exactly the interval
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd500);   // behind the last tick
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd1999);
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd2000);
        settle();

        // --- directed: disabled queue, flush still drains ---
        write_reg(rgdq_pkg::CFG_QUEUE_ENABLED, 10'd0);
        add_item(rgdq_pkg::REQ_PUSH,  $urandom(), 64'd5000);
        add_item(rgdq_pkg::REQ_POP,   32'h0, 64'h0);
        add_item(rgdq_pkg::REQ_FLUSH, 32'h0, 64'h0);
        add_item(REQ_BOGUS, $urandom(), 64'h0);
        settle();

        // --- directed: narrowest gate ---
        write_reg(rgdq_pkg::CFG_QUEUE_ENABLED, 10'd1);
        write_reg(rgdq_pkg::CFG_FRAME_INTERVAL, 10'd1);
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd2000);  // same tick: skipped
        add_item(rgdq_pkg::REQ_PUSH, $urandom(), 64'd2001);
        settle();

        // --- random phases, one setting each ---
        tick_now = 64'd3000;
        for (p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       gap_pick = 10'd0;
                1, 6:    gap_pick = 10'd1000;
                2:       gap_pick = 10'd1;
                7:       gap_pick = 10'd0;
                default: gap_pick = rgdq_pkg::INTERVAL_W'($urandom_range(2, 999));
            endcase
            en_pick = (p != 4);
            write_reg(rgdq_pkg::CFG_FRAME_INTERVAL, gap_pick);
            write_reg(rgdq_pkg::CFG_QUEUE_ENABLED,
                      {{(rgdq_pkg::CFG_DATA_W-1){1'b0}}, en_pick});
            calm = (p == 6);

            for (i = 0; i < PHASE_LEN; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    // push: mostly advancing ticks near the interval so the
                    // gate both passes and skips; free ticks only with gate off
                    if (gap_ms == 0 && $urandom_range(0, 3) == 0)
                        t = {$urandom(), $urandom()};
                    else if ($urandom_range(0, 9) == 0)
                        t = tick_now - $urandom_range(0, gap_ms);
                    else
                    begin
                        tick_now = tick_now + $urandom_range(0, 2 * gap_ms + 1);
                        t        = tick_now;
                    end
                    add_item(rgdq_pkg::REQ_PUSH, $urandom(), t);
                end
                else if (roll < 80)
                    add_item(rgdq_pkg::REQ_POP, $urandom(), {$urandom(), $urandom()});
                else if (roll < 92)
                    add_item(rgdq_pkg::REQ_FLUSH, $urandom(), {$urandom(), $urandom()});
                else
                    add_item(REQ_BOGUS, $urandom(), {$urandom(), $urandom()});
            end
            settle();
        end
        calm = 1'b0;

        // --- closing: gate against the top of the tick range ---
        write_reg(rgdq_pkg::CFG_FRAME_INTERVAL, 10'd1000);
        add_item(rgdq_pkg::REQ_PUSH,  $urandom(), TICK_MAX - 64'd5);
        add_item(rgdq_pkg::REQ_PUSH,  $urandom(), TICK_MAX);   // 5 ms later: skipped
        add_item(rgdq_pkg::REQ_FLUSH, 32'h0, 64'h0);
        settle();

        if (expected_rsp_q.size() != 0)
            note_mismatch($sformatf("%0d responses never arrived", expected_rsp_q.size()));

        $display("Covered %0d requests over %0d register settings, %0d responses checked",
                 items_sent, N_PHASES + 5, rsp_seen);
        $display("  with %0d evictions, %0d flushed entries, %0d rate skips, %0d errors",
                 evictions_seen, flush_entries_seen, skips_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rgdq_pkg.sv
hdl/rgdq_chan_if.sv
hdl/rgdq_rate_gate.sv
hdl/rate_gated_drop_oldest_queue.sv
tb/tb_rate_gated_drop_oldest_queue.sv
